[design/mdmm_pkg.sv]
`timescale 1ns / 1ps

package mdmm_pkg;

    // Commands carried on s_tuser
    localparam logic [1:0] CMD_PLAIN = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Frame modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam int PREAMBLE_BITS_DEF = 32;
    localparam int DATA_W            = 16;
    localparam int ADDR_W            = 5;
    localparam int POS_W             = 6;
    localparam int SEND_W            = 32;
    localparam int READ_HDR_BITS     = 14;

    // Start-of-frame, opcode and turnaround patterns
    localparam logic [3:0] ST_OP_READ  = 4'b0110;
    localparam logic [3:0] ST_OP_WRITE = 4'b0101;
    localparam logic [1:0] TA_WRITE    = 2'b10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic              start_rd;
        logic              start_wr;
        logic [ADDR_W-1:0] phy_addr;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
        logic              mdio_in;
    } cmd_item_t;

    // Queue handshake between front and back
    typedef struct packed {
        logic      valid;
        cmd_item_t item;
    } queue_head_t;

    // One result item
    typedef struct packed {
        logic              rejected;
        logic              read_done;
        logic [DATA_W-1:0] read_data;
        logic              busy_res;
        logic              mdc_pulse;
        logic              mdio_drive;
        logic              mdio_out;
    } result_t;

endpackage

[design/mdio_management_master_unit.sv]
`timescale 1ns / 1ps

// Clause 22 MDIO management master.
// Every input transaction on the s_ channel stands for one management clock
// period; s_tuser carries the command (plain period, start read, start write),
// s_tdata the addresses, write value and the sampled line level. A start taken
// while idle opens a frame of PREAMBLE_BITS + 32 periods, counted from that
// same transaction. A start during a running frame is flagged as rejected.
// Every input transaction yields exactly one m_ transaction: line level, drive
// enable, clock pulse, busy flag, and on the last period of a read frame the
// captured 16-bit value with read_done.
// Two register stages (queue entry, then output register) lie between an input
// transaction and its result. Throughput: one transaction per cycle while the m_
// side accepts, set by the single period step of the frame sequencer.
// A two-entry queue parts the command front from the sequencer, so a stalled
// m_ side fills the queue and only then drops s_tready; results are held
// until taken. Reset empties the queue, clears the output valid and ends the frame.
module mdio_management_master_unit #(
    parameter int PREAMBLE_BITS = mdmm_pkg::PREAMBLE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // phy_addr[4:0], reg_addr[9:5], write_data[25:10], mdio_in[26], zero[31:27]
    input  logic [mdmm_pkg::S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mdio_out[0], mdio_drive[1], mdc_pulse[2], busy_res[3], read_data[19:4],
    // read_done[20], rejected[21], zero[23:22]
    output logic [mdmm_pkg::M_TDATA_W-1:0] m_tdata
);
    import mdmm_pkg::*;

    queue_head_t q_head;
    logic        q_pop;
    result_t     m_result;

    mdmm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_head   (q_head),
        .q_pop    (q_pop)
    );

    mdmm_back #(
        .PREAMBLE_BITS (PREAMBLE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {(M_TDATA_W - $bits(result_t))'(0), m_result};

    // A finished read ends the frame with a pulse on a released line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[20]) |-> (m_tdata[2] && !m_tdata[3] && !m_tdata[1]))
        else $error("read_done without a final released clock period");

    // Without a clock pulse the line is neither driven nor busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[2]) |-> (!m_tdata[1] && !m_tdata[0] && !m_tdata[3]))
        else $error("idle period drives the line or reports busy");

    // The queue only fills up behind a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without a stalled output");

endmodule

[design/mdmm_front.sv]
`timescale 1ns / 1ps

module mdmm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mdmm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    output mdmm_pkg::queue_head_t          q_head,
    input  logic                           q_pop
);
    import mdmm_pkg::*;

    localparam int QDEPTH = 2;

    cmd_item_t          entry_reg [QDEPTH];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push;
    cmd_item_t          item_in;

    assign s_tready = (count_reg != 2'(QDEPTH));
    assign push     = s_tvalid && s_tready;

    // Classify the command; code 3 acts as a plain period
    always_comb begin
        item_in.start_rd   = (s_tuser == CMD_READ);
        item_in.start_wr   = (s_tuser == CMD_WRITE);
        item_in.phy_addr   = s_tdata[ADDR_W-1:0];
        item_in.reg_addr   = s_tdata[2*ADDR_W-1:ADDR_W];
        item_in.write_data = s_tdata[2*ADDR_W+DATA_W-1:2*ADDR_W];
        item_in.mdio_in    = s_tdata[2*ADDR_W+DATA_W];
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

endmodule

[design/mdmm_back.sv]
`timescale 1ns / 1ps

module mdmm_back #(
    parameter int PREAMBLE_BITS = mdmm_pkg::PREAMBLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mdmm_pkg::queue_head_t q_head,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mdmm_pkg::result_t     m_result
);
    import mdmm_pkg::*;

    localparam logic [POS_W-1:0] PRE_LEN   = POS_W'(PREAMBLE_BITS);
    localparam logic [POS_W:0]   FRAME_LEN = (POS_W+1)'(PREAMBLE_BITS + SEND_W);

    logic [1:0]        mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SEND_W-1:0] send_reg, send_next;
    logic [DATA_W-1:0] recv_reg, recv_next;
    logic              valid_reg;
    result_t           result_reg, result_next;

    logic              start_ok;
    logic [1:0]        mode_eff;
    logic [POS_W-1:0]  pos_eff;
    logic [SEND_W-1:0] send_eff;
    logic [DATA_W-1:0] recv_eff;
    logic [POS_W-1:0]  q_raw;
    logic [POS_W:0]    pos_inc;
    logic              in_pre;
    logic              hdr;
    cmd_item_t         it;

    assign it    = q_head.item;
    assign q_pop = q_head.valid && (!valid_reg || m_tready);

    always_comb begin
        start_ok = (it.start_rd || it.start_wr) && (mode_reg == MODE_IDLE);
        mode_eff = mode_reg;
        pos_eff  = pos_reg;
        send_eff = send_reg;
        recv_eff = recv_reg;
        if (start_ok) begin
            pos_eff = '0;
            if (it.start_rd) begin
                mode_eff = MODE_READ;
                send_eff = {ST_OP_READ, it.phy_addr, it.reg_addr,
                            (SEND_W-READ_HDR_BITS)'(0)};
                recv_eff = '0;
            end else begin
                mode_eff = MODE_WRITE;
                send_eff = {ST_OP_WRITE, it.phy_addr, it.reg_addr, TA_WRITE, it.write_data};
            end
        end

        in_pre  = (pos_eff < PRE_LEN);
        q_raw   = pos_eff - PRE_LEN;
        hdr     = (mode_eff == MODE_WRITE) || (q_raw[4:0] < 5'(READ_HDR_BITS));
        pos_inc = {1'b0, pos_eff} + 1'b1;

        mode_next   = mode_eff;
        pos_next    = pos_eff;
        send_next   = send_eff;
        recv_next   = recv_eff;
        result_next = '0;
        result_next.rejected = (it.start_rd || it.start_wr) && !start_ok;

        if (mode_eff != MODE_IDLE) begin
            result_next.mdc_pulse = 1'b1;
            if (in_pre) begin
                result_next.mdio_out   = 1'b1;
                result_next.mdio_drive = 1'b1;
            end else if (hdr) begin
                // shift the frame out MSB first
                result_next.mdio_out   = send_eff[SEND_W-1];
                result_next.mdio_drive = 1'b1;
                send_next              = {send_eff[SEND_W-2:0], 1'b0};
            end else begin
                recv_next = {recv_eff[DATA_W-2:0], it.mdio_in};
            end
            if (pos_inc >= FRAME_LEN) begin
                if (mode_eff == MODE_READ) begin
                    result_next.read_done = 1'b1;
                    result_next.read_data = recv_next;
                end
                mode_next = MODE_IDLE;
                pos_next  = '0;
            end else begin
                pos_next             = pos_inc[POS_W-1:0];
                result_next.busy_res = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            send_reg  <= '0;
            recv_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                mode_reg <= mode_next;
                pos_reg  <= pos_next;
                send_reg <= send_next;
                recv_reg <= recv_next;
            end
            if (q_pop) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule
